### hdl/paged_bump_suballocator_top_assert.svh
// assertion macros for the sub-allocator
`ifndef PAGED_BUMP_SUBALLOCATOR_TOP_ASSERT_SVH
`define PAGED_BUMP_SUBALLOCATOR_TOP_ASSERT_SVH

// property that holds in the cycle after a trigger
`define PBS_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("assertion failed");

// property that holds whenever the trigger is seen
`define PBS_ASSERT_NOW(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("assertion failed");

`endif

### hdl/pbsa_pkg.sv
package pbsa_pkg;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StCheck = 7'b0000010,
    StGrow  = 7'b0000100,
    StScan  = 7'b0001000,
    StTake  = 7'b0010000,
    StFin   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;      // capture request, start checks
    logic release_all;
    logic grow_init;
    logic grow_step;
    logic scan_init;
    logic scan_step;
    logic take;      // take chosen/new page
    logic commit;    // bump offset and counters
    logic fail;      // failed allocation result
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic fits;
    logic grow_done;
    logic grow_over;
    logic scan_done;
    logic can_take;
  } sts_t;

endpackage

### hdl/pbsa_ctrl.sv
module pbsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pbsa_pkg::sts_t sts_i,
  output pbsa_pkg::cmd_t cmd_o
);
  import pbsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.is_release) begin
          cmd_o.release_all = 1'b1;
          state_d = StOut;
        end else if (sts_i.fits) begin
          cmd_o.commit = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.grow_init = 1'b1;
          state_d = StGrow;
        end
      end
      StGrow: begin
        if (sts_i.grow_over) begin
          cmd_o.fail = 1'b1;
          state_d = StOut;
        end else if (sts_i.grow_done) begin
          cmd_o.scan_init = 1'b1;
          state_d = StScan;
        end else begin
          cmd_o.grow_step = 1'b1;
        end
      end
      StScan: begin
        if (sts_i.scan_done) begin
          state_d = StTake;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StTake: begin
        if (sts_i.can_take) begin
          cmd_o.take = 1'b1;
          state_d = StFin;
        end else begin
          cmd_o.fail = 1'b1;
          state_d = StOut;
        end
      end
      StFin: begin
        if (sts_i.fits) begin
          cmd_o.commit = 1'b1;
        end else begin
          cmd_o.fail = 1'b1;
        end
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

### hdl/pbsa_dp.sv
module pbsa_dp #(
  parameter int MaxPages = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [37:0]    in_data_i,
  input  pbsa_pkg::cmd_t cmd_i,
  output pbsa_pkg::sts_t sts_o,
  output logic [157:0]   out_data_o
);
  import pbsa_pkg::*;

  localparam int SW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int CW = $clog2(MaxPages + 1);

  logic [31:0] base_q;
  logic [31:0] psize_q [MaxPages];
  logic [MaxPages-1:0] pool_q, held_q;
  logic [CW-1:0] created_q;
  logic [SW-1:0] cur_slot_q;
  logic cur_valid_q;
  logic [31:0] cur_off_q, room_q;
  logic [39:0] used_q, alig_q, alloc_q, used_pk_q, alig_pk_q, alloc_pk_q;

  logic kind_q;
  logic [31:0] req_q;
  logic [4:0] alog_q;
  logic [32:0] need_q;
  logic [CW-1:0] scan_q;
  logic best_v_q;
  logic [SW-1:0] best_q;
  logic took_q, ok_q;
  logic [SW-1:0] slot_out_q;
  logic [31:0] off_out_q;
  // aligned offset and pad for the current page
  logic [32:0] amask, aligned_w, adj_w;
  logic [31:0] pad_w;

  assign amask     = (33'd1 << alog_q) - 33'd1;
  assign aligned_w = ({1'b0, cur_off_q} + amask) & ~amask;
  assign pad_w     = aligned_w[31:0] - cur_off_q;
  assign adj_w     = {1'b0, req_q} + {1'b0, pad_w};

  always_comb begin
    sts_o.is_release = kind_q;
    sts_o.fits       = cur_valid_q && !aligned_w[32] && (adj_w <= {1'b0, room_q});
    sts_o.grow_over  = need_q[32];
    sts_o.grow_done  = (need_q >= {1'b0, req_q});
    sts_o.scan_done  = ({1'b0, scan_q} >= {1'b0, created_q});
    sts_o.can_take   = best_v_q || (32'(created_q) < 32'(MaxPages));
  end

  logic [SW-1:0] scan_idx;
  logic [SW-1:0] take_idx;
  assign scan_idx = scan_q[SW-1:0];
  assign take_idx = best_v_q ? best_q : created_q[SW-1:0];

  function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? Max40 : s[39:0];
  endfunction

  logic [39:0] alloc_new;
  assign alloc_new = sat_add(alloc_q, {8'd0, psize_q[take_idx]});

  logic [39:0] used_new, alig_new;
  assign used_new = sat_add(used_q, {8'd0, req_q});
  assign alig_new = sat_add(alig_q, {7'd0, adj_w});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i[0];
      req_q  <= in_data_i[32:1];
      alog_q <= in_data_i[37:33];
    end
    if (cmd_i.grow_init) begin
      need_q <= (base_q == 32'd0) ? 33'd1 : {1'b0, base_q};
    end else if (cmd_i.grow_step) begin
      need_q <= {need_q[31:0], 1'b0};
    end
    if (cmd_i.scan_init) begin
      scan_q   <= '0;
      best_v_q <= 1'b0;
      best_q   <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + CW'(1);
      if (pool_q[scan_idx] && (psize_q[scan_idx] >= need_q[31:0]) &&
          (!best_v_q || psize_q[scan_idx] < psize_q[best_q])) begin
        best_v_q <= 1'b1;
        best_q   <= scan_idx;
      end
    end
    if (cmd_i.take && !best_v_q) begin
      psize_q[take_idx] <= need_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd65536;
      pool_q <= '0;
      held_q <= '0;
      created_q <= '0;
      cur_slot_q <= '0;
      cur_valid_q <= 1'b0;
      cur_off_q <= '0;
      room_q <= '0;
      used_q <= '0; alig_q <= '0; alloc_q <= '0;
      used_pk_q <= '0; alig_pk_q <= '0; alloc_pk_q <= '0;
      took_q <= 1'b0; ok_q <= 1'b0;
      slot_out_q <= '0; off_out_q <= '0;
    end else begin
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (cmd_i.load) begin
        took_q <= 1'b0;
      end
      if (cmd_i.release_all) begin
        pool_q <= pool_q | held_q;
        held_q <= '0;
        cur_valid_q <= 1'b0;
        cur_off_q <= '0;
        room_q <= '0;
        used_q <= '0; alig_q <= '0; alloc_q <= '0;
        ok_q <= 1'b1; slot_out_q <= '0; off_out_q <= '0;
      end
      if (cmd_i.take) begin
        // take a pooled or new page; commit or fail follows on the taken page
        if (!best_v_q) created_q <= created_q + CW'(1);
        pool_q[take_idx] <= 1'b0;
        held_q[take_idx] <= 1'b1;
        cur_slot_q <= take_idx;
        cur_valid_q <= 1'b1;
        cur_off_q <= '0;
        room_q <= best_v_q ? psize_q[take_idx] : need_q[31:0];
        begin
          logic [39:0] an;
          an = best_v_q ? alloc_new : sat_add(alloc_q, {7'd0, need_q});
          alloc_q <= an;
          if (an > alloc_pk_q) alloc_pk_q <= an;
        end
        took_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        room_q <= room_q - adj_w[31:0];
        cur_off_q <= cur_off_q + adj_w[31:0];
        used_q <= used_new;
        alig_q <= alig_new;
        if (used_new > used_pk_q) used_pk_q <= used_new;
        if (alig_new > alig_pk_q) alig_pk_q <= alig_new;
        ok_q <= 1'b1;
        slot_out_q <= cur_slot_q;
        off_out_q <= aligned_w[31:0];
      end
      if (cmd_i.fail) begin
        ok_q <= 1'b0; took_q <= 1'b0;
        slot_out_q <= '0; off_out_q <= '0;
      end
    end
  end

  logic [3:0] slot4;
  assign slot4 = 4'(slot_out_q);
  assign out_data_o = {alloc_pk_q, alig_pk_q, used_pk_q, took_q, off_out_q, slot4, ok_q};

endmodule

### hdl/paged_bump_suballocator_top.sv
// paged bump sub-allocator
// input stream s_axis: tuser = kind; tdata = req_size, align_log2 (37 bits,
// padded to 40).
// one result per request on m_axis: ok, page_slot, range_offset, took_page and
// the three 40-bit peaks (158 bits, padded to 160).
// the user writes base_page_size on the cfg channel only while idle; not enforced.
// a release or a request that fits the current page goes from the check state
// straight to its result; a page miss doubles the page size one step a cycle
// and then scans the created slots of the page table one slot a cycle (up to
// MAX_PAGES slots) before it takes a page.
// one request is in flight at a time: s_axis_tready is high only while idle,
// so a new request can be taken in the cycle after the result is accepted.
// the result is held on m_axis until m_axis_tready; no new request is taken
// before that.
// reset clears the page table, the counters and the peaks and loads a base
// page size of 65536; the pool is empty after reset.
module paged_bump_suballocator_top #(
  parameter int MAX_PAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // req_size, align_log2
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata    // ok, page_slot, range_offset, took_page,
                                       // peak_used, peak_aligned, peak_allocated
);
  import pbsa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [157:0] res;
  logic req_acc;

  assign cfg_ready_o = 1'b1;
  assign req_acc = s_axis_tvalid && s_axis_tready;

  pbsa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pbsa_dp #(.MaxPages(MAX_PAGES)) u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_data_i,
    .in_data_i({s_axis_tdata[36:32], s_axis_tdata[31:0], s_axis_tuser}),
    .cmd_i(cmd), .sts_o(sts), .out_data_o(res)
  );

  assign m_axis_tdata = {2'd0, res};

`include "paged_bump_suballocator_top_assert.svh"

  `PBS_ASSERT_NOW(a_busy_no_take, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `PBS_ASSERT_NEXT(a_take_starts, clk_i, rst_ni, req_acc, !s_axis_tready && !m_axis_tvalid)
  `PBS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule
